### design/ltbp_pkg.sv
`default_nettype none

package ltbp_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int FILL_W      = $clog2(BLOCK_BYTES);
    localparam int REP_W       = 10;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic CFG_IDLE_TIMEOUT = 1'b0;
    localparam logic CFG_FILE_LIMIT   = 1'b1;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic [REP_W-1:0] repeat_count;
        logic             block_last;
        logic             file_last;
        logic             run_last;
    } out_item_t;

    // one queued command: a data byte (maybe with mark) or a padding request
    typedef struct packed {
        logic            pad;
        logic [7:0]      data_byte;
        logic            mark;
        logic [5:0][7:0] digits;
    } cmd_t;

    typedef struct packed {
        logic head_valid;
        logic full;
    } qstat_t;

    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd60)      t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    function automatic logic [7:0] tens_char(input logic [5:0] v);
        return CH_ZERO + {4'd0, tens_of(v)};
    endfunction

    function automatic logic [7:0] ones_char(input logic [5:0] v);
        logic [5:0] tens10;
        logic [5:0] rem;
        tens10 = {2'd0, tens_of(v)} * 6'd10;
        rem    = v - tens10;
        return CH_ZERO + {2'd0, rem};
    endfunction

endpackage

`default_nettype wire

### design/ltbp_front.sv
`default_nettype none

module ltbp_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire ltbp_pkg::in_item_t in_data,
    input  wire logic [31:0]       idle_timeout,
    input  wire ltbp_pkg::qstat_t  qstat,
    output logic                   push,
    output ltbp_pkg::cmd_t         push_cmd
);
    import ltbp_pkg::*;

    logic [7:0]  prev_byte_reg, prev_byte_next;
    logic [31:0] idle_count_reg, idle_count_next;
    logic        accept;
    logic        pad_req;

    assign in_stall = qstat.full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        prev_byte_next  = prev_byte_reg;
        idle_count_next = idle_count_reg;
        pad_req         = 1'b0;
        if (accept)
        begin
            if (in_data.kind == KIND_DATA)
            begin
                idle_count_next = 32'd0;
                prev_byte_next  = in_data.data_byte;
            end
            else
            begin
                if (idle_count_reg != 32'hFFFF_FFFF)
                    idle_count_next = idle_count_reg + 32'd1;
                pad_req = idle_count_next > idle_timeout;
            end
        end
    end

    // ticks that leave the idle count at or below the timeout leave no trace downstream
    assign push = accept && ((in_data.kind == KIND_DATA) || pad_req);

    always_comb
    begin
        push_cmd.pad       = (in_data.kind == KIND_TICK);
        push_cmd.data_byte = in_data.data_byte;
        push_cmd.mark      = (in_data.kind == KIND_DATA) && (prev_byte_reg == CH_CR)
                             && (in_data.data_byte == CH_LF);
        push_cmd.digits[0] = tens_char({1'b0, in_data.hour});
        push_cmd.digits[1] = ones_char({1'b0, in_data.hour});
        push_cmd.digits[2] = tens_char(in_data.minute);
        push_cmd.digits[3] = ones_char(in_data.minute);
        push_cmd.digits[4] = tens_char(in_data.second);
        push_cmd.digits[5] = ones_char(in_data.second);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_byte_reg  <= 8'd0;
            idle_count_reg <= 32'd0;
        end
        else
        begin
            prev_byte_reg  <= prev_byte_next;
            idle_count_reg <= idle_count_next;
        end
    end

endmodule

`default_nettype wire

### design/ltbp_queue.sv
`default_nettype none

module ltbp_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire ltbp_pkg::cmd_t  push_cmd,
    input  wire logic            pop,
    output ltbp_pkg::qstat_t     qstat,
    output ltbp_pkg::cmd_t       head_cmd
);
    import ltbp_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign qstat.full       = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.head_valid = (count_reg != '0);
    assign head_cmd         = slot_reg[rd_ptr_reg];

    assign do_push = push && !qstat.full;
    assign do_pop  = pop && qstat.head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### design/ltbp_back.sv
`default_nettype none

module ltbp_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ltbp_pkg::qstat_t qstat,
    input  wire ltbp_pkg::cmd_t   head_cmd,
    output logic                  pop,
    input  wire logic [31:0]      file_limit,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output ltbp_pkg::out_item_t   out_data
);
    import ltbp_pkg::*;

    // positions within a byte plus time mark
    localparam logic [3:0] SEQ_BYTE  = 4'd0;
    localparam logic [3:0] SEQ_OPEN  = 4'd1;
    localparam logic [3:0] SEQ_H10   = 4'd2;
    localparam logic [3:0] SEQ_H1    = 4'd3;
    localparam logic [3:0] SEQ_C1    = 4'd4;
    localparam logic [3:0] SEQ_M10   = 4'd5;
    localparam logic [3:0] SEQ_M1    = 4'd6;
    localparam logic [3:0] SEQ_C2    = 4'd7;
    localparam logic [3:0] SEQ_S10   = 4'd8;
    localparam logic [3:0] SEQ_S1    = 4'd9;
    localparam logic [3:0] SEQ_CLOSE = 4'd10;
    localparam logic [3:0] SEQ_SPACE = 4'd11;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [31:0]       file_bytes_reg, file_bytes_next;
    logic [3:0]        seq_reg, seq_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic              advance, last, emit;
    logic [7:0]        cur_char;
    logic [FILL_W:0]   fill_plus;
    logic [32:0]       file_sum;
    logic [31:0]       rep_wide;

    assign advance   = qstat.head_valid && (!out_valid_reg || !out_stall);
    assign last      = head_cmd.pad || !head_cmd.mark || (seq_reg == SEQ_SPACE);
    assign emit      = !head_cmd.pad || (fill_reg != '0);
    assign pop       = advance && last;
    assign fill_plus = {1'b0, fill_reg} + 1'b1;
    assign file_sum  = {1'b0, file_bytes_reg} + 33'(BLOCK_BYTES);
    assign rep_wide  = 32'(BLOCK_BYTES) - 32'(fill_reg);

    always_comb
    begin
        case (seq_reg)
            SEQ_BYTE:  cur_char = head_cmd.data_byte;
            SEQ_OPEN:  cur_char = CH_OPEN;
            SEQ_H10:   cur_char = head_cmd.digits[0];
            SEQ_H1:    cur_char = head_cmd.digits[1];
            SEQ_C1:    cur_char = CH_COLON;
            SEQ_M10:   cur_char = head_cmd.digits[2];
            SEQ_M1:    cur_char = head_cmd.digits[3];
            SEQ_C2:    cur_char = CH_COLON;
            SEQ_S10:   cur_char = head_cmd.digits[4];
            SEQ_S1:    cur_char = head_cmd.digits[5];
            SEQ_CLOSE: cur_char = CH_CLOSE;
            SEQ_SPACE: cur_char = CH_SPACE;
            default:   cur_char = CH_SPACE;
        endcase
    end

    always_comb
    begin
        fill_next       = fill_reg;
        file_bytes_next = file_bytes_reg;
        seq_next        = seq_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (advance)
        begin
            seq_next = last ? SEQ_BYTE : seq_reg + 4'd1;
            if (head_cmd.pad)
            begin
                if (emit)
                begin
                    // pad the partial block and close the file
                    out_data_next.out_byte     = CH_SPACE;
                    out_data_next.repeat_count = rep_wide[REP_W-1:0];
                    out_data_next.block_last   = 1'b1;
                    out_data_next.file_last    = 1'b1;
                    out_data_next.run_last     = 1'b1;
                    out_valid_next             = 1'b1;
                    fill_next                  = '0;
                    file_bytes_next            = 32'd0;
                end
            end
            else
            begin
                out_data_next.out_byte     = cur_char;
                out_data_next.repeat_count = REP_W'(1);
                out_data_next.block_last   = 1'b0;
                out_data_next.file_last    = 1'b0;
                out_data_next.run_last     = last;
                out_valid_next             = 1'b1;
                fill_next                  = fill_plus[FILL_W-1:0];
                if (fill_plus == (FILL_W + 1)'(BLOCK_BYTES))
                begin
                    out_data_next.block_last = 1'b1;
                    fill_next                = '0;
                    if (file_sum >= {1'b0, file_limit})
                    begin
                        out_data_next.file_last = 1'b1;
                        file_bytes_next         = 32'd0;
                    end
                    else
                    begin
                        file_bytes_next = file_sum[31:0];
                    end
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            file_bytes_reg <= 32'd0;
            seq_reg        <= SEQ_BYTE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fill_reg       <= fill_next;
            file_bytes_reg <= file_bytes_next;
            seq_reg        <= seq_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### design/line_timestamp_block_packer_core.sv
// line time-stamp block packer
//
// input channel (in_valid / in_stall / in_data): one word per received
// console byte (kind data) or per idle tick (kind tick). output channel
// (out_valid / out_stall / out_data): one word per byte placed in the block
// stream, or one padding word carrying a run of spaces in repeat_count.
// after a CR LF pair the LF is followed by the 11-character "(HH:MM:SS) "
// mark, so one data word yields 1 or 12 output words; run_last marks the
// final one. words are counted into 512-byte blocks (block_last), and a
// block that brings the file size to at least file_limit also carries
// file_last. words pass a queue slot and the back end's single output
// register, which sets throughput at one word a cycle while out_stall is
// low; a mark run holds the back end while the front fills the 4-deep
// command queue, and in_stall rises only when that queue is full.
// out_stall holds the output word and backs up the queue. reset clears
// counters, the queue and the idle count and loads idle_timeout=1000 and
// file_limit=1048576. the user must write configuration through cfg_we /
// cfg_index / cfg_wdata while the block is idle; nothing enforces it.
`default_nettype none

module line_timestamp_block_packer_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire ltbp_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output ltbp_pkg::out_item_t     out_data,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [31:0]        cfg_wdata
);
    import ltbp_pkg::*;

    logic [31:0] idle_timeout_reg;
    logic [31:0] file_limit_reg;
    qstat_t      qstat;
    logic        push, pop;
    cmd_t        push_cmd, head_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg <= 32'd1000;
            file_limit_reg   <= 32'd1048576;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_wdata;
                CFG_FILE_LIMIT:   file_limit_reg   <= cfg_wdata;
                default:          idle_timeout_reg <= idle_timeout_reg;
            endcase
        end
    end

    ltbp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .idle_timeout (idle_timeout_reg),
        .qstat        (qstat),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    ltbp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .qstat    (qstat),
        .head_cmd (head_cmd)
    );

    ltbp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .qstat      (qstat),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .file_limit (file_limit_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

### design/ltbp_checker.sv
`default_nettype none

module ltbp_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire ltbp_pkg::out_item_t out_data
);
    import ltbp_pkg::*;

    // a held word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    a_file_needs_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.file_last |-> out_data.block_last)
        else $error("file_last without block_last");

    // only a padding run carries more than one copy
    a_pad_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.repeat_count != REP_W'(1)) |->
            (out_data.out_byte == CH_SPACE) && out_data.block_last
            && out_data.file_last && out_data.run_last)
        else $error("malformed padding word");

    a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.repeat_count != '0)
        else $error("zero repeat count");

endmodule

bind line_timestamp_block_packer_core ltbp_checker u_ltbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
